// ===== rtl/bfas_pkg.sv =====
package bfas_pkg;

    localparam logic [31:0] VELOCITY_LIMIT = 32'd65536;
    localparam logic [31:0] STEP_LIMIT     = 32'd655;
    localparam logic [23:0] DT_LIMIT       = 24'd1677722;

    localparam int W = 72;

    localparam logic signed [W-1:0] BIG_RAW  = W'(64'sd1 <<< 40);
    localparam logic signed [W-1:0] BIG_BACK = W'(64'sd1 <<< 36);
    localparam logic signed [W-1:0] MAX_ENERGY = W'(64'sd2147483647);

    typedef enum logic [1:0] {
        OP_STEP    = 2'd0,
        OP_PROBE   = 2'd1,
        OP_ENGAGE  = 2'd2,
        OP_RELEASE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BOUNDED    = 3'd1,
        ST_DEADBAND   = 3'd2,
        ST_NOT_ENGAGED = 3'd3,
        ST_BAD_INPUT  = 3'd4,
        ST_BAD_DT     = 3'd5,
        ST_INFEASIBLE = 3'd6,
        ST_ENERGY     = 3'd7
    } status_t;

    typedef enum logic [2:0] {
        REG_INV_MASS = 3'd0,
        REG_DAMPING  = 3'd1,
        REG_STIFF    = 3'd2,
        REG_DEADBAND = 3'd3,
        REG_OFF_LIM  = 3'd4,
        REG_ACC_LIM  = 3'd5,
        REG_JERK_LIM = 3'd6,
        REG_EN_LIM   = 3'd7
    } reg_idx_t;

    typedef enum logic [1:0] {
        MM_Q16 = 2'd0,
        MM_DT  = 2'd1,
        MM_DIV = 2'd2
    } mul_mode_t;

    function automatic logic signed [W-1:0] clamp_sym(
        input logic signed [W-1:0] v,
        input logic signed [W-1:0] lim
    );
        logic signed [W-1:0] r;
        begin
            r = v;
            if (v > lim)
                r = lim;
            else if (v < -lim)
                r = -lim;
            return r;
        end
    endfunction

    function automatic logic [W-1:0] mag(input logic signed [W-1:0] a);
        begin
            return a[W-1] ? W'(-a) : W'(a);
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [W-1:0] v);
        logic signed [31:0] r;
        begin
            if (v > W'(64'sd2147483647))
                r = 32'sh7fffffff;
            else if (v < -W'(64'sd2147483648))
                r = 32'sh80000000;
            else
                r = v[31:0];
            return r;
        end
    endfunction

endpackage

// ===== rtl/bounded_force_admittance_step_unit.sv =====
// channel   direction  signals
// in        to block   in_valid/in_ready, operation..time_step
// out       from block out_valid/out_ready, accepted..inside_deadband
// cfg       to block   cfg_valid/cfg_ready, cfg_index, cfg_data
// a step takes 11 passes of one shift-add multiply / restoring divide unit;
// an infeasible step stops after the jerk pass, and engage, release and
// early rejects go straight to the output register
// async active-low reset clears state, registers to their reset values
// in_ready is low while a beat is in work; a finished beat waits in the
// output register, and the sequencer holds its last state until that is free
module bounded_force_admittance_step_unit
    import bfas_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         operation,
    input  logic signed [31:0] measured_force,
    input  logic signed [31:0] target_force,
    input  logic signed [31:0] measured_velocity,
    input  logic [23:0]        time_step,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               accepted,
    output logic [2:0]         status,
    output logic signed [31:0] new_offset,
    output logic signed [31:0] new_velocity,
    output logic signed [31:0] new_acceleration,
    output logic [30:0]        new_energy,
    output logic signed [31:0] force_error,
    output logic signed [31:0] shaped_error,
    output logic               limited,
    output logic               inside_deadband,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE, S_DAMP, S_STIFF, S_IMASS, S_JDT, S_VDT, S_SDT, S_OFF,
        S_RVEL, S_RACC, S_JERK, S_CHK, S_PWR, S_EDT, S_FIN, S_OUT
    } state_t;

    state_t state_reg;
    logic [30:0] inv_mass_reg, damping_reg, stiff_reg, deadband_reg;
    logic [30:0] off_lim_reg, acc_lim_reg, jerk_lim_reg, en_lim_reg;
    logic signed [31:0] off_reg, vel_reg, acc_reg, en_reg;
    logic engaged_reg;

    logic        op_probe_reg;
    logic signed [31:0] fm_reg, vm_reg;
    logic [23:0] dt_reg;
    logic signed [W-1:0] t_reg, u_reg, step_off_reg, rvel_reg, racc_reg;
    logic        lim_reg;
    logic        out_valid_reg, acc_o_reg, lim_o_reg, ins_o_reg;
    status_t     st_o_reg;
    logic signed [31:0] off_o_reg, vel_o_reg, accn_o_reg, err_o_reg, shp_o_reg;
    logic [30:0] en_o_reg;

    logic        res_acc_reg, res_lim_reg, res_ins_reg;
    status_t     res_st_reg;
    logic signed [31:0] res_off_reg, res_vel_reg, res_accn_reg, res_err_reg, res_shp_reg;
    logic [30:0] res_en_reg;

    logic        ar_start;
    mul_mode_t   ar_mode;
    logic signed [W-1:0] ar_a, ar_cap;
    logic [31:0] ar_b;
    logic        ar_done;
    logic signed [W-1:0] ar_res;

    bfas_arith u_arith (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (ar_start),
        .mode   (ar_mode),
        .a      (ar_a),
        .b      (ar_b),
        .cap    (ar_cap),
        .done   (ar_done),
        .result (ar_res)
    );

    logic started_reg;
    logic signed [W-1:0] err_w, mag_err, shp_w, vsum, esum, unc, offc;
    logic signed [W-1:0] acc_cl, vel_cl, stp_cl;
    logic out_load;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_load  = (state_reg == S_OUT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        ar_start = (state_reg != S_IDLE) && (state_reg != S_OUT)
                   && (state_reg != S_OFF) && (state_reg != S_CHK)
                   && (state_reg != S_FIN) && !started_reg;
        ar_mode = MM_Q16;
        ar_a    = '0;
        ar_b    = '0;
        ar_cap  = BIG_RAW;
        case (state_reg)
            S_DAMP:
            begin
                ar_a = W'(vel_reg);
                ar_b = 32'(damping_reg);
            end
            S_STIFF:
            begin
                ar_a = W'(off_reg);
                ar_b = 32'(stiff_reg);
            end
            S_IMASS:
            begin
                ar_a = t_reg;
                ar_b = 32'(inv_mass_reg);
            end
            S_JDT:
            begin
                ar_mode = MM_DT;
                ar_a = W'(jerk_lim_reg);
                ar_b = 32'(dt_reg);
            end
            S_VDT:
            begin
                ar_mode = MM_DT;
                ar_a = t_reg;
                ar_b = 32'(dt_reg);
            end
            S_SDT:
            begin
                ar_mode = MM_DT;
                ar_a = t_reg;
                ar_b = 32'(dt_reg);
            end
            S_RVEL:
            begin
                ar_mode = MM_DIV;
                ar_a = u_reg;
                ar_b = 32'(dt_reg);
                ar_cap = BIG_BACK;
            end
            S_RACC:
            begin
                ar_mode = MM_DIV;
                ar_a = rvel_reg - W'(vel_reg);
                ar_b = 32'(dt_reg);
                ar_cap = BIG_BACK;
            end
            S_JERK:
            begin
                ar_mode = MM_DIV;
                ar_a = racc_reg - W'(acc_reg);
                ar_b = 32'(dt_reg);
                ar_cap = BIG_BACK;
            end
            S_PWR:
            begin
                ar_a = W'(fm_reg);
                ar_b = 32'(mag(W'(vm_reg)));
            end
            S_EDT:
            begin
                ar_mode = MM_DT;
                ar_a = t_reg;
                ar_b = 32'(dt_reg);
            end
            default:
            begin
                ar_start = 1'b0;
            end
        endcase
        err_w = W'(measured_force) - W'(target_force);
        err_w = W'(sat32(err_w));
        mag_err = mag(err_w);
        shp_w = err_w[W-1] ? -(mag_err - W'(deadband_reg)) : (mag_err - W'(deadband_reg));
        acc_cl = clamp_sym(ar_res, W'(acc_lim_reg));
        vsum = W'(vel_reg) + ar_res;
        vel_cl = clamp_sym(vsum, W'(VELOCITY_LIMIT));
        stp_cl = clamp_sym(ar_res, W'(STEP_LIMIT));
        esum = W'(en_reg) + ar_res;
        if (esum < 0)
            esum = '0;
        if (esum > MAX_ENERGY)
            esum = MAX_ENERGY;
        unc = step_off_reg + W'(off_reg);
        offc = unc;
        if (unc < 0)
            offc = '0;
        if (offc > W'(off_lim_reg))
            offc = W'(off_lim_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            started_reg <= 1'b0;
            inv_mass_reg <= 31'd65536;
            damping_reg  <= '0;
            stiff_reg    <= '0;
            deadband_reg <= '0;
            off_lim_reg  <= 31'd655;
            acc_lim_reg  <= 31'd65536;
            jerk_lim_reg <= 31'd655360;
            en_lim_reg   <= 31'd65536;
            off_reg <= '0;
            vel_reg <= '0;
            acc_reg <= '0;
            en_reg  <= '0;
            engaged_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            res_acc_reg  <= 1'b0;
            res_st_reg   <= ST_OK;
            res_off_reg  <= '0;
            res_vel_reg  <= '0;
            res_accn_reg <= '0;
            res_en_reg   <= '0;
            res_err_reg  <= '0;
            res_shp_reg  <= '0;
            res_lim_reg  <= 1'b0;
            res_ins_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (reg_idx_t'(cfg_index))
                    REG_INV_MASS: inv_mass_reg <= cfg_data[30:0];
                    REG_DAMPING:  damping_reg  <= cfg_data[30:0];
                    REG_STIFF:    stiff_reg    <= cfg_data[30:0];
                    REG_DEADBAND: deadband_reg <= cfg_data[30:0];
                    REG_OFF_LIM:  off_lim_reg  <= cfg_data[30:0];
                    REG_ACC_LIM:  acc_lim_reg  <= cfg_data[30:0];
                    REG_JERK_LIM: jerk_lim_reg <= cfg_data[30:0];
                    default:      en_lim_reg   <= cfg_data[30:0];
                endcase
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            if (ar_start)
                started_reg <= 1'b1;
            if (ar_done)
                started_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready) begin
                        op_probe_reg <= (operation == OP_PROBE);
                        fm_reg <= measured_force;
                        vm_reg <= measured_velocity;
                        dt_reg <= time_step;
                        lim_reg <= 1'b0;
                        acc_o_reg <= 1'b0;
                        lim_o_reg <= 1'b0;
                        ins_o_reg <= 1'b0;
                        err_o_reg <= '0;
                        shp_o_reg <= '0;
                        off_o_reg <= off_reg;
                        vel_o_reg <= vel_reg;
                        accn_o_reg <= acc_reg;
                        en_o_reg <= en_reg[30:0];
                        if (operation == OP_ENGAGE || operation == OP_RELEASE) begin
                            off_reg <= '0;
                            vel_reg <= '0;
                            acc_reg <= '0;
                            en_reg <= '0;
                            engaged_reg <= (operation == OP_ENGAGE);
                            off_o_reg <= '0;
                            vel_o_reg <= '0;
                            accn_o_reg <= '0;
                            en_o_reg <= '0;
                            st_o_reg <= ST_OK;
                            state_reg <= S_OUT;
                        end else if (!engaged_reg) begin
                            st_o_reg <= ST_NOT_ENGAGED;
                            state_reg <= S_OUT;
                        end else if (target_force < 0) begin
                            st_o_reg <= ST_BAD_INPUT;
                            state_reg <= S_OUT;
                        end else if (time_step == '0 || time_step > DT_LIMIT) begin
                            st_o_reg <= ST_BAD_DT;
                            state_reg <= S_OUT;
                        end else begin
                            err_o_reg <= err_w[31:0];
                            if (mag_err <= W'(deadband_reg)) begin
                                ins_o_reg <= 1'b1;
                                shp_o_reg <= '0;
                                t_reg <= '0;
                            end else begin
                                shp_o_reg <= shp_w[31:0];
                                t_reg <= shp_w;
                            end
                            state_reg <= S_DAMP;
                        end
                    end
                end
                S_DAMP:
                begin
                    if (ar_done) begin
                        t_reg <= t_reg - ar_res;
                        state_reg <= S_STIFF;
                    end
                end
                S_STIFF:
                begin
                    if (ar_done) begin
                        t_reg <= t_reg - ar_res;
                        state_reg <= S_IMASS;
                    end
                end
                S_IMASS:
                begin
                    if (ar_done) begin
                        if (acc_cl != ar_res)
                            lim_reg <= 1'b1;
                        u_reg <= acc_cl - W'(acc_reg);
                        state_reg <= S_JDT;
                    end
                end
                S_JDT:
                begin
                    if (ar_done) begin
                        if (u_reg > ar_res || u_reg < -ar_res)
                            lim_reg <= 1'b1;
                        t_reg <= W'(acc_reg) + clamp_sym(u_reg, ar_res);
                        state_reg <= S_VDT;
                    end
                end
                S_VDT:
                begin
                    if (ar_done) begin
                        if (vel_cl != vsum)
                            lim_reg <= 1'b1;
                        t_reg <= vel_cl;
                        state_reg <= S_SDT;
                    end
                end
                S_SDT:
                begin
                    if (ar_done) begin
                        if (stp_cl != ar_res)
                            lim_reg <= 1'b1;
                        step_off_reg <= stp_cl;
                        state_reg <= S_OFF;
                    end
                end
                S_OFF:
                begin
                    if (offc != unc)
                        lim_reg <= 1'b1;
                    step_off_reg <= offc;
                    u_reg <= offc - W'(off_reg);
                    state_reg <= S_RVEL;
                end
                S_RVEL:
                begin
                    if (ar_done) begin
                        rvel_reg <= ar_res;
                        state_reg <= S_RACC;
                    end
                end
                S_RACC:
                begin
                    if (ar_done) begin
                        racc_reg <= ar_res;
                        state_reg <= S_JERK;
                    end
                end
                S_JERK:
                begin
                    if (ar_done) begin
                        t_reg <= ar_res;
                        state_reg <= S_CHK;
                    end
                end
                S_CHK:
                begin
                    lim_o_reg <= lim_reg;
                    if (mag(racc_reg) > W'(acc_lim_reg) + W'(1)
                        || mag(t_reg) > W'(jerk_lim_reg) + W'(1)) begin
                        st_o_reg <= ST_INFEASIBLE;
                        state_reg <= S_OUT;
                    end else begin
                        state_reg <= S_PWR;
                    end
                end
                S_PWR:
                begin
                    if (ar_done) begin
                        t_reg <= vm_reg[31] ? -ar_res : ar_res;
                        state_reg <= S_EDT;
                    end
                end
                S_EDT:
                begin
                    if (ar_done) begin
                        t_reg <= esum;
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (t_reg > W'(en_lim_reg)) begin
                        st_o_reg <= ST_ENERGY;
                    end else begin
                        acc_o_reg <= 1'b1;
                        st_o_reg <= lim_reg ? ST_BOUNDED
                                  : (ins_o_reg ? ST_DEADBAND : ST_OK);
                        off_o_reg <= step_off_reg[31:0];
                        vel_o_reg <= sat32(rvel_reg);
                        accn_o_reg <= sat32(racc_reg);
                        en_o_reg <= t_reg[30:0];
                        if (!op_probe_reg) begin
                            off_reg <= step_off_reg[31:0];
                            vel_reg <= sat32(rvel_reg);
                            acc_reg <= sat32(racc_reg);
                            en_reg <= t_reg[31:0];
                        end
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_load) begin
                        res_acc_reg  <= acc_o_reg;
                        res_st_reg   <= st_o_reg;
                        res_off_reg  <= off_o_reg;
                        res_vel_reg  <= vel_o_reg;
                        res_accn_reg <= accn_o_reg;
                        res_en_reg   <= en_o_reg;
                        res_err_reg  <= err_o_reg;
                        res_shp_reg  <= shp_o_reg;
                        res_lim_reg  <= lim_o_reg;
                        res_ins_reg  <= ins_o_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid        = out_valid_reg;
    assign accepted         = res_acc_reg;
    assign status           = res_st_reg;
    assign new_offset       = res_off_reg;
    assign new_velocity     = res_vel_reg;
    assign new_acceleration = res_accn_reg;
    assign new_energy       = res_en_reg;
    assign force_error      = res_err_reg;
    assign shaped_error     = res_shp_reg;
    assign limited          = res_lim_reg;
    assign inside_deadband  = res_ins_reg;

endmodule

// ===== rtl/bfas_arith.sv =====
module bfas_arith
    import bfas_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  mul_mode_t           mode,
    input  logic signed [W-1:0] a,
    input  logic [31:0]         b,
    input  logic signed [W-1:0] cap,
    output logic                done,
    output logic signed [W-1:0] result
);

    localparam int PW = 2 * W;

    logic [PW-1:0]      acc_reg, acc_next;
    logic [W-1:0]       mcand_reg, mcand_next;
    logic [31:0]        mplier_reg, mplier_next;
    logic [6:0]         cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               neg_reg, neg_next;
    mul_mode_t          mode_reg, mode_next;
    logic signed [W-1:0] cap_reg, cap_next;
    logic [W-1:0]       rem_reg, rem_next;
    logic [W-1:0]       quo_reg, quo_next;
    logic [W-1:0]       dnum_reg, dnum_next;
    logic               done_reg, done_next;
    logic signed [W-1:0] res_reg, res_next;

    logic [W-1:0] m_a;
    logic [PW-1:0] prod_sh;
    logic [W-1:0] pmag;
    logic [W-1:0] rem_sh;

    always_comb
    begin
        m_a = mag(a);
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        neg_next    = neg_reg;
        mode_next   = mode_reg;
        cap_next    = cap_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        dnum_next   = dnum_reg;
        done_next   = 1'b0;
        res_next    = res_reg;
        prod_sh     = '0;
        pmag        = '0;
        rem_sh      = '0;
        if (start && !busy_reg) begin
            busy_next  = 1'b1;
            neg_next   = a[W-1];
            mode_next  = mode;
            cap_next   = cap;
            acc_next   = '0;
            mcand_next = m_a;
            mplier_next = b;
            rem_next   = '0;
            quo_next   = '0;
            dnum_next  = m_a << 24;
            cnt_next   = (mode == MM_DIV) ? 7'(W) : 7'd32;
        end else if (busy_reg) begin
            if (mode_reg == MM_DIV) begin
                rem_sh = {rem_reg[W-2:0], dnum_reg[W-1]};
                dnum_next = dnum_reg << 1;
                if (rem_sh >= W'(mplier_reg)) begin
                    rem_next = rem_sh - W'(mplier_reg);
                    quo_next = {quo_reg[W-2:0], 1'b1};
                end else begin
                    rem_next = rem_sh;
                    quo_next = {quo_reg[W-2:0], 1'b0};
                end
            end else begin
                if (mplier_reg[0])
                    acc_next = acc_reg + (PW'(mcand_reg) << (32 - int'(cnt_reg)));
                mplier_next = mplier_reg >> 1;
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                case (mode_reg)
                    MM_Q16:
                    begin
                        prod_sh = acc_next >> 16;
                        pmag = (prod_sh > PW'(cap_reg)) ? W'(cap_reg) : W'(prod_sh);
                    end
                    MM_DT:
                    begin
                        prod_sh = acc_next >> 24;
                        pmag = W'(prod_sh);
                    end
                    default:
                    begin
                        pmag = (quo_next > W'(cap_reg)) ? W'(cap_reg) : quo_next;
                    end
                endcase
                res_next = neg_reg ? W'(-pmag) : W'(pmag);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        neg_reg    <= neg_next;
        mode_reg   <= mode_next;
        cap_reg    <= cap_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        dnum_reg   <= dnum_next;
        res_reg    <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

// ===== sim/tb_bounded_force_admittance_step_unit.sv =====
module tb_bounded_force_admittance_step_unit;
    import bfas_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint CYCLE_LIMIT = 4000000;
    localparam longint RAW_CAP     = longint'(1) <<< 40;
    localparam longint BACK_CAP    = longint'(1) <<< 36;
    localparam longint ENERGY_CAP  = 64'sd2147483647;

    typedef struct {
        logic        accepted;
        logic [2:0]  status;
        logic [31:0] new_offset;
        logic [31:0] new_velocity;
        logic [31:0] new_acceleration;
        logic [30:0] new_energy;
        logic [31:0] force_error;
        logic [31:0] shaped_error;
        logic        limited;
        logic        inside_deadband;
    } tick_res_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         operation = OP_STEP;
    logic signed [31:0] measured_force = '0;
    logic signed [31:0] target_force = '0;
    logic signed [31:0] measured_velocity = '0;
    logic [23:0]        time_step = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               accepted;
    logic [2:0]         status;
    logic signed [31:0] new_offset;
    logic signed [31:0] new_velocity;
    logic signed [31:0] new_acceleration;
    logic [30:0]        new_energy;
    logic signed [31:0] force_error;
    logic signed [31:0] shaped_error;
    logic               limited;
    logic               inside_deadband;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = REG_INV_MASS;
    logic [31:0]        cfg_data = '0;

    bounded_force_admittance_step_unit dut (.*);

    always #5 clk = ~clk;

    // predictor copy of registers and state
    longint unsigned cf_reg [8];
    longint          st_off, st_vel, st_acc, st_en;
    bit              st_engaged;

    tick_res_t expected_ticks [$];
    int        mismatches = 0;
    longint    cycles = 0;
    int        burst_left = 0;

    function automatic longint unsigned mag_of(input longint a);
        return a < 0 ? 64'd0 - longint'(a) : a;
    endfunction

    function automatic longint signed_of(input bit neg, input longint unsigned m);
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint q16_mul(input longint a, input longint unsigned b,
                                       input longint cap);
        longint unsigned m, p;
        begin
            m = mag_of(a);
            if (b != 0 && m > {64{1'b1}} / b)
                p = cap;
            else begin
                p = (m * b) >> 16;
                if (p > longint'(cap))
                    p = cap;
            end
            return signed_of(a < 0, p);
        end
    endfunction

    function automatic longint dt_mul(input longint a, input longint unsigned dt);
        longint unsigned m, p;
        begin
            m = mag_of(a);
            p = (m >> 24) * dt + (((m & 64'hFFFFFF) * dt) >> 24);
            return signed_of(a < 0, p);
        end
    endfunction

    function automatic longint dt_div(input longint num, input longint unsigned dt);
        longint q;
        begin
            q = (num * 64'sd16777216) / longint'(dt);
            if (q > BACK_CAP)
                q = BACK_CAP;
            if (q < -BACK_CAP)
                q = -BACK_CAP;
            return q;
        end
    endfunction

    function automatic longint clip(input longint v, input longint lim, inout bit flag);
        if (v > lim) begin
            flag = 1'b1;
            return lim;
        end
        if (v < -lim) begin
            flag = 1'b1;
            return -lim;
        end
        return v;
    endfunction

    function automatic longint sat_32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic tick_res_t admit_predict(input logic [1:0] op,
                                                input logic signed [31:0] fm,
                                                input logic signed [31:0] ft,
                                                input logic signed [31:0] vm,
                                                input logic [23:0] dtv);
        longint r_off, r_vel, r_acc, r_en, err, shaped, sum, acc, vel, stp;
        longint unc, off, rvel, racc, jerk, energy, f_meas, f_tgt, v_meas;
        longint unsigned dt, m;
        bit lim, ins, ok;
        logic [2:0] st;
        tick_res_t r;
        begin
            f_meas = fm;
            f_tgt = ft;
            v_meas = vm;
            dt = dtv;
            r_off = st_off;
            r_vel = st_vel;
            r_acc = st_acc;
            r_en = st_en;
            err = 0;
            shaped = 0;
            lim = 0;
            ins = 0;
            ok = 0;
            r = '{default: '0};
            if (op == OP_ENGAGE || op == OP_RELEASE) begin
                st_off = 0;
                st_vel = 0;
                st_acc = 0;
                st_en = 0;
                st_engaged = (op == OP_ENGAGE);
                return r;
            end
            if (!st_engaged)
                st = ST_NOT_ENGAGED;
            else if (f_tgt < 0)
                st = ST_BAD_INPUT;
            else if (dt == 0 || dt > DT_LIMIT)
                st = ST_BAD_DT;
            else begin
                err = sat_32(f_meas - f_tgt);
                m = mag_of(err);
                if (m <= cf_reg[REG_DEADBAND]) begin
                    ins = 1;
                    shaped = 0;
                end else
                    shaped = signed_of(err < 0, m - cf_reg[REG_DEADBAND]);
                sum = shaped - q16_mul(r_vel, cf_reg[REG_DAMPING], RAW_CAP)
                      - q16_mul(r_off, cf_reg[REG_STIFF], RAW_CAP);
                acc = q16_mul(sum, cf_reg[REG_INV_MASS], RAW_CAP);
                acc = clip(acc, cf_reg[REG_ACC_LIM], lim);
                acc = r_acc + clip(acc - r_acc, dt_mul(cf_reg[REG_JERK_LIM], dt), lim);
                vel = clip(r_vel + dt_mul(acc, dt), longint'(VELOCITY_LIMIT), lim);
                stp = clip(dt_mul(vel, dt), longint'(STEP_LIMIT), lim);
                unc = r_off + stp;
                off = unc;
                if (off < 0)
                    off = 0;
                if (off > longint'(cf_reg[REG_OFF_LIM]))
                    off = cf_reg[REG_OFF_LIM];
                if (off != unc)
                    lim = 1;
                rvel = dt_div(off - r_off, dt);
                racc = dt_div(rvel - r_vel, dt);
                jerk = dt_div(racc - r_acc, dt);
                if (mag_of(racc) > cf_reg[REG_ACC_LIM] + 1
                    || mag_of(jerk) > cf_reg[REG_JERK_LIM] + 1)
                    st = ST_INFEASIBLE;
                else begin
                    energy = r_en + dt_mul(q16_mul(f_meas, mag_of(v_meas), RAW_CAP)
                                           * (v_meas < 0 ? -1 : 1), dt);
                    if (energy < 0)
                        energy = 0;
                    if (energy > ENERGY_CAP)
                        energy = ENERGY_CAP;
                    if (energy > longint'(cf_reg[REG_EN_LIM]))
                        st = ST_ENERGY;
                    else begin
                        ok = 1;
                        st = lim ? ST_BOUNDED : (ins ? ST_DEADBAND : ST_OK);
                        r_off = off;
                        r_vel = sat_32(rvel);
                        r_acc = sat_32(racc);
                        r_en = energy;
                        if (op == OP_STEP) begin
                            st_off = r_off;
                            st_vel = r_vel;
                            st_acc = r_acc;
                            st_en = r_en;
                        end
                    end
                end
            end
            r.accepted = ok;
            r.status = st;
            r.new_offset = r_off[31:0];
            r.new_velocity = r_vel[31:0];
            r.new_acceleration = r_acc[31:0];
            r.new_energy = r_en[30:0];
            r.force_error = err[31:0];
            r.shaped_error = shaped[31:0];
            r.limited = lim;
            r.inside_deadband = ins;
            return r;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result side: random stall patterns on out_ready
    initial begin : result_checker
        int mode;
        int count;
        tick_res_t e;
        mode = 0;
        count = 0;
        forever begin
            @(negedge clk);
            if (count == 0) begin
                mode = $urandom_range(0, 3);
                count = 64;
            end
            count--;
            case (mode)
                0: out_ready = 1'b1;
                1: out_ready = 1'($urandom_range(0, 1));
                2: out_ready = ($urandom_range(0, 3) == 0);
                default: out_ready = (count % 8) < 5;
            endcase
            @(posedge clk);
            if (rst_n && out_valid && out_ready) begin
                if (expected_ticks.size() == 0)
                    report_mismatch("unexpected beat", 32'(status), 32'd0);
                else begin
                    e = expected_ticks.pop_front();
                    if (accepted !== e.accepted)
                        report_mismatch("accepted", 32'(accepted), 32'(e.accepted));
                    if (status !== e.status)
                        report_mismatch("status", 32'(status), 32'(e.status));
                    if (new_offset !== e.new_offset)
                        report_mismatch("new_offset", new_offset, e.new_offset);
                    if (new_velocity !== e.new_velocity)
                        report_mismatch("new_velocity", new_velocity, e.new_velocity);
                    if (new_acceleration !== e.new_acceleration)
                        report_mismatch("new_acceleration", new_acceleration,
                                        e.new_acceleration);
                    if (new_energy !== e.new_energy)
                        report_mismatch("new_energy", 32'(new_energy), 32'(e.new_energy));
                    if (force_error !== e.force_error)
                        report_mismatch("force_error", force_error, e.force_error);
                    if (shaped_error !== e.shaped_error)
                        report_mismatch("shaped_error", shaped_error, e.shaped_error);
                    if (limited !== e.limited)
                        report_mismatch("limited", 32'(limited), 32'(e.limited));
                    if (inside_deadband !== e.inside_deadband)
                        report_mismatch("inside_deadband", 32'(inside_deadband),
                                        32'(e.inside_deadband));
                end
            end
        end
    end

    task automatic send_tick(input logic [1:0] op, input logic [31:0] fm,
                             input logic [31:0] ft, input logic [31:0] vm,
                             input logic [23:0] dtv);
        int gap;
        @(negedge clk);
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        operation = op;
        measured_force = fm;
        target_force = ft;
        measured_velocity = vm;
        time_step = dtv;
        in_valid = 1'b1;
        forever begin
            #1;
            if (in_ready)
                break;
            @(negedge clk);
        end
        expected_ticks.push_back(admit_predict(op, fm, ft, vm, dtv));
        @(posedge clk);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        burst_left = 0;
        while (expected_ticks.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic set_reg(input reg_idx_t idx, input logic [31:0] value);
        wait_drained();
        cfg_index = idx;
        cfg_data = value;
        cfg_valid = 1'b1;
        forever begin
            #1;
            if (cfg_ready)
                break;
            @(negedge clk);
        end
        cf_reg[idx] = value & 32'h7FFFFFFF;
        @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [31:0] pick_force();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 32'h000FFFFF) - 32'h00080000;
            default: return $urandom_range(0, 32'h00280000) - 32'h00140000;
        endcase
    endfunction

    function automatic logic [31:0] pick_target();
        case ($urandom_range(0, 5))
            0: return {1'b0, 31'($urandom)};
            default: return $urandom_range(0, 32'h00140000);
        endcase
    endfunction

    function automatic logic [31:0] pick_velocity();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return 32'd0;
            default: return $urandom_range(0, 32'h00020000) - 32'h00010000;
        endcase
    endfunction

    function automatic logic [23:0] pick_dt();
        case ($urandom_range(0, 7))
            0: return 24'($urandom_range(1, 200));
            1: return 24'($urandom_range(1, DT_LIMIT));
            2: return DT_LIMIT;
            default: return 24'($urandom_range(8000, 40000));
        endcase
    endfunction

    function automatic logic [31:0] pick_reg_value(input reg_idx_t idx);
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return (idx == REG_DAMPING || idx == REG_STIFF || idx == REG_DEADBAND)
                      ? 32'd0 : 32'd1;
            2: return $urandom_range(1, 32'h00100000);
            default: return $urandom_range(1, 32'h00020000);
        endcase
    endfunction

    task automatic random_tick();
        int r;
        logic [1:0] op;
        r = $urandom_range(0, 99);
        op = ($urandom_range(0, 3) == 0) ? OP_PROBE : OP_STEP;
        if (r < 4)
            send_tick(OP_ENGAGE, $urandom, $urandom, $urandom, 24'($urandom));
        else if (r < 6)
            send_tick(OP_RELEASE, $urandom, $urandom, $urandom, 24'($urandom));
        else if (r < 9)
            send_tick(op, pick_force(), {1'b1, 31'($urandom)}, pick_velocity(),
                      pick_dt());
        else if (r < 12)
            send_tick(op, pick_force(), pick_target(), pick_velocity(),
                      ($urandom_range(0, 1) ? 24'd0
                       : 24'($urandom_range(DT_LIMIT + 1, 24'hFFFFFF))));
        else
            send_tick(op, pick_force(), pick_target(), pick_velocity(), pick_dt());
    endtask

    task automatic randomize_regs();
        reg_idx_t idx;
        for (int i = 0; i < 8; i++) begin
            idx = reg_idx_t'(i);
            set_reg(idx, {1'($urandom), 31'(pick_reg_value(idx))});
        end
    endtask

    task automatic test_not_engaged();
        send_tick(OP_STEP, 32'h00010000, 32'h00008000, 32'h00000100, 24'd16777);
        send_tick(OP_PROBE, 32'h00010000, 32'h00008000, 32'h00000100, 24'd16777);
        send_tick(OP_RELEASE, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 24'hFFFFFF);
        send_tick(OP_STEP, 32'h00010000, 32'hFFFF0000, 32'h0, 24'd0);
    endtask

    task automatic test_early_rejects();
        send_tick(OP_ENGAGE, 0, 0, 0, 0);
        send_tick(OP_STEP, 32'h00010000, 32'h80000000, 32'h0, 24'd16777);
        send_tick(OP_STEP, 32'h00010000, 32'h00000000, 32'h0, 24'd0);
        send_tick(OP_STEP, 32'h00010000, 32'h00000000, 32'h0, DT_LIMIT + 24'd1);
        send_tick(OP_PROBE, 32'h00010000, 32'h00000000, 32'h0, 24'hFFFFFF);
        send_tick(OP_STEP, 32'h00010000, 32'h00000000, 32'h00001000, DT_LIMIT);
    endtask

    task automatic test_extremes();
        set_reg(REG_DEADBAND, 32'h00008000);
        send_tick(OP_ENGAGE, 0, 0, 0, 0);
        send_tick(OP_STEP, 32'h00004000, 32'h00000000, 32'h0, 24'd16777);
        send_tick(OP_STEP, 32'h7FFFFFFF, 32'h00000000, 32'h7FFFFFFF, 24'd16777);
        send_tick(OP_STEP, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 24'd1);
        send_tick(OP_PROBE, 32'hFFFF0000, 32'h00010000, 32'h00010000, 24'd16777);
        send_tick(OP_STEP, 32'h00020000, 32'h00010000, 32'hFFFF0000, 24'd1);
        send_tick(OP_STEP, 32'h00100000, 32'h00000000, 32'h0, 24'd16777);
        send_tick(OP_STEP, 32'h00100000, 32'h00000000, 32'h00010000, DT_LIMIT);
        send_tick(OP_RELEASE, 0, 0, 0, 0);
        send_tick(OP_STEP, 32'h00100000, 32'h00000000, 32'h0, 24'd16777);
    endtask

    task automatic run_phase(input int n);
        send_tick(OP_ENGAGE, 0, 0, 0, 0);
        repeat (n) random_tick();
    endtask

    task automatic test_config_sweep();
        for (int i = 0; i < 8; i++)
            set_reg(reg_idx_t'(i), 32'h7FFFFFFF);
        run_phase(20);
        set_reg(REG_INV_MASS, 32'h1);
        set_reg(REG_DAMPING, 32'h0);
        set_reg(REG_STIFF, 32'h0);
        set_reg(REG_DEADBAND, 32'h0);
        set_reg(REG_OFF_LIM, 32'h1);
        set_reg(REG_ACC_LIM, 32'h1);
        set_reg(REG_JERK_LIM, 32'h1);
        set_reg(REG_EN_LIM, 32'h1);
        run_phase(20);
        set_reg(REG_INV_MASS, 32'h00010000);
        set_reg(REG_DAMPING, 32'h00040000);
        set_reg(REG_STIFF, 32'h00200000);
        set_reg(REG_DEADBAND, 32'h00002000);
        set_reg(REG_OFF_LIM, 32'h00010000);
        set_reg(REG_ACC_LIM, 32'h00100000);
        set_reg(REG_JERK_LIM, 32'h01000000);
        set_reg(REG_EN_LIM, 32'h00100000);
        run_phase(30);
    endtask

    task automatic test_random();
        for (int i = 0; i < 450; i++) begin
            if (i % 110 == 55)
                wait_drained();
            if (i % 150 == 0)
                randomize_regs();
            if (i % 60 == 0)
                send_tick(OP_ENGAGE, 0, 0, 0, 0);
            random_tick();
        end
    endtask

    initial begin
        cf_reg = '{65536, 0, 0, 0, 655, 65536, 655360, 65536};
        st_off = 0;
        st_vel = 0;
        st_acc = 0;
        st_en = 0;
        st_engaged = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_not_engaged();
        test_early_rejects();
        test_extremes();
        test_config_sweep();
        test_random();
        wait_drained();
        repeat (50) @(posedge clk);
        if (mismatches == 0 && expected_ticks.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
